@@ hw/rtl/leg_balance_compensator_top_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LEG_BALANCE_COMPENSATOR_TOP_DEFINES_SVH
`define LEG_BALANCE_COMPENSATOR_TOP_DEFINES_SVH

// Antecedent in one cycle, consequent in the next, ignored while in reset.
`define LBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Same form, but also checked across reset.
`define LBC_ASSERT_NEXT_ANY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("%m: check across reset failed");

`endif

@@ hw/rtl/lbc_pkg.sv @@
package lbc_pkg;

    localparam int unsigned AngW   = 16;
    localparam int unsigned StW    = 24;
    localparam int unsigned WideW  = 27;
    localparam int unsigned AddrW  = 5;
    localparam int unsigned DataW  = 32;

    // Register map, one 32-bit word per register
    typedef enum logic [2:0] {
        REG_FORCE_LOW       = 3'd0,
        REG_FORCE_HIGH      = 3'd1,
        REG_FLATTEN_RATE    = 3'd2,
        REG_PITCH_STR_RATE  = 3'd3,
        REG_ROLL_STR_RATE   = 3'd4,
        REG_SPRING_RATE     = 3'd5,
        REG_DAMP_RATE       = 3'd6,
        REG_LOAD_RATE       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [AngW-1:0] force_low;
        logic signed [AngW-1:0] force_high;
        logic signed [AngW-1:0] flatten_rate;
        logic signed [AngW-1:0] pitch_rate;
        logic signed [AngW-1:0] roll_rate;
        logic signed [AngW-1:0] spring_rate;
        logic signed [AngW-1:0] damp_rate;
        logic signed [AngW-1:0] load_rate;
    } t_cfg;

    typedef struct packed {
        logic                   side;
        logic signed [AngW-1:0] foot_fz;
        logic signed [AngW-1:0] foot_mx;
        logic signed [AngW-1:0] foot_my;
        logic signed [AngW-1:0] tilt_x;
        logic signed [AngW-1:0] tilt_y;
        logic                   single_support;
        logic signed [AngW-1:0] knee_measured;
        logic signed [AngW-1:0] knee_ref;
        logic signed [AngW-1:0] ankle_roll_ref;
        logic signed [AngW-1:0] ankle_pitch_ref;
        logic signed [AngW-1:0] hip_pitch_ref;
    } t_item;

    typedef struct packed {
        logic signed [StW-1:0] roll_flatten;
        logic signed [StW-1:0] pitch_flatten;
        logic signed [StW-1:0] roll_resist;
        logic signed [StW-1:0] pitch_resist;
        logic signed [StW-1:0] knee_rate;
        logic signed [StW-1:0] knee_shift;
    } t_leg_state;

    // Clamp a wide sum to the state range
    function automatic logic signed [StW-1:0] sat_st(input logic signed [WideW-1:0] v);
        logic signed [WideW-1:0] hi;
        logic signed [WideW-1:0] lo;
        hi = WideW'(signed'({1'b0, {(StW-1){1'b1}}}));
        lo = WideW'(signed'({1'b1, {(StW-1){1'b0}}}));
        if (v > hi) begin
            sat_st = hi[StW-1:0];
        end else if (v < lo) begin
            sat_st = lo[StW-1:0];
        end else begin
            sat_st = v[StW-1:0];
        end
    endfunction

    // Clamp a wide sum to the angle range
    function automatic logic signed [AngW-1:0] sat_ang(input logic signed [WideW-1:0] v);
        logic signed [WideW-1:0] hi;
        logic signed [WideW-1:0] lo;
        hi = WideW'(signed'({1'b0, {(AngW-1){1'b1}}}));
        lo = WideW'(signed'({1'b1, {(AngW-1){1'b0}}}));
        if (v > hi) begin
            sat_ang = hi[AngW-1:0];
        end else if (v < lo) begin
            sat_ang = lo[AngW-1:0];
        end else begin
            sat_ang = v[AngW-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/leg_balance_compensator_top.sv @@
// Items pass through the stage 1, stage 2 and stage 3 registers to o_valid.
// Throughput: one item per cycle unless stalled; legs may arrive in any order.
// The leg state read-modify-write sits in the middle stage.
// Reset (synchronous, active low) clears the config registers, both legs'
// integrators and the pipeline valids.
module leg_balance_compensator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_side,
    input  logic signed [15:0]         i_foot_fz,
    input  logic signed [15:0]         i_foot_mx,
    input  logic signed [15:0]         i_foot_my,
    input  logic signed [15:0]         i_tilt_x,
    input  logic signed [15:0]         i_tilt_y,
    input  logic                       i_single_support,
    input  logic signed [15:0]         i_knee_measured,
    input  logic signed [15:0]         i_knee_ref,
    input  logic signed [15:0]         i_ankle_roll_ref,
    input  logic signed [15:0]         i_ankle_pitch_ref,
    input  logic signed [15:0]         i_hip_pitch_ref,
    // result item channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_leg,
    output logic signed [15:0]         o_ankle_roll_cmd,
    output logic signed [15:0]         o_ankle_pitch_cmd,
    output logic signed [15:0]         o_knee_cmd,
    output logic signed [15:0]         o_hip_pitch_cmd,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lbc_pkg::AddrW-1:0]  paddr,
    input  logic [lbc_pkg::DataW-1:0]  pwdata,
    output logic [lbc_pkg::DataW-1:0]  prdata,
    output logic                       pready
);

    localparam int unsigned AngW  = lbc_pkg::AngW;
    localparam int unsigned StW   = lbc_pkg::StW;
    localparam int unsigned WideW = lbc_pkg::WideW;
    localparam int unsigned DataW = lbc_pkg::DataW;

    typedef struct packed {
        logic                   side;
        logic signed [AngW-1:0] knee_ref;
        logic signed [AngW-1:0] ankle_roll_ref;
        logic signed [AngW-1:0] ankle_pitch_ref;
        logic signed [AngW-1:0] hip_pitch_ref;
        lbc_pkg::t_leg_state    st;
    } t_mid;

    lbc_pkg::t_cfg       r_cfg;
    lbc_pkg::t_item      r_item;
    lbc_pkg::t_leg_state new_st;
    lbc_pkg::t_reg_idx   wr_idx;
    t_mid                r_mid;

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic wr_en;
    logic [AngW-1:0] rd_val;

    logic signed [StW-2:0]   h;
    logic signed [WideW-1:0] sum_ar, sum_ap, sum_kn, sum_hp;

    // Register port: writes land on the access cycle, reads are direct
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = lbc_pkg::t_reg_idx'(paddr[lbc_pkg::AddrW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (wr_idx)
                lbc_pkg::REG_FORCE_LOW:      r_cfg.force_low    <= pwdata[AngW-1:0];
                lbc_pkg::REG_FORCE_HIGH:     r_cfg.force_high   <= pwdata[AngW-1:0];
                lbc_pkg::REG_FLATTEN_RATE:   r_cfg.flatten_rate <= pwdata[AngW-1:0];
                lbc_pkg::REG_PITCH_STR_RATE: r_cfg.pitch_rate   <= pwdata[AngW-1:0];
                lbc_pkg::REG_ROLL_STR_RATE:  r_cfg.roll_rate    <= pwdata[AngW-1:0];
                lbc_pkg::REG_SPRING_RATE:    r_cfg.spring_rate  <= pwdata[AngW-1:0];
                lbc_pkg::REG_DAMP_RATE:      r_cfg.damp_rate    <= pwdata[AngW-1:0];
                lbc_pkg::REG_LOAD_RATE:      r_cfg.load_rate    <= pwdata[AngW-1:0];
                default:                     r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            lbc_pkg::REG_FORCE_LOW:      rd_val = r_cfg.force_low;
            lbc_pkg::REG_FORCE_HIGH:     rd_val = r_cfg.force_high;
            lbc_pkg::REG_FLATTEN_RATE:   rd_val = r_cfg.flatten_rate;
            lbc_pkg::REG_PITCH_STR_RATE: rd_val = r_cfg.pitch_rate;
            lbc_pkg::REG_ROLL_STR_RATE:  rd_val = r_cfg.roll_rate;
            lbc_pkg::REG_SPRING_RATE:    rd_val = r_cfg.spring_rate;
            lbc_pkg::REG_DAMP_RATE:      rd_val = r_cfg.damp_rate;
            lbc_pkg::REG_LOAD_RATE:      rd_val = r_cfg.load_rate;
            default:                     rd_val = '0;
        endcase
    end

    assign prdata = DataW'(rd_val);

    // Stage readiness: a stage may load when it is empty or its item moves on
    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    // Stage 1: capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_item.side            <= i_side;
            r_item.foot_fz         <= i_foot_fz;
            r_item.foot_mx         <= i_foot_mx;
            r_item.foot_my         <= i_foot_my;
            r_item.tilt_x          <= i_tilt_x;
            r_item.tilt_y          <= i_tilt_y;
            r_item.single_support  <= i_single_support;
            r_item.knee_measured   <= i_knee_measured;
            r_item.knee_ref        <= i_knee_ref;
            r_item.ankle_roll_ref  <= i_ankle_roll_ref;
            r_item.ankle_pitch_ref <= i_ankle_pitch_ref;
            r_item.hip_pitch_ref   <= i_hip_pitch_ref;
        end
    end

    // Stage 2: update the leg state once, as the item leaves stage 1
    lbc_leg_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (r_v1 && rdy2),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_state (new_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_mid.side            <= r_item.side;
            r_mid.knee_ref        <= r_item.knee_ref;
            r_mid.ankle_roll_ref  <= r_item.ankle_roll_ref;
            r_mid.ankle_pitch_ref <= r_item.ankle_pitch_ref;
            r_mid.hip_pitch_ref   <= r_item.hip_pitch_ref;
            r_mid.st              <= new_st;
        end
    end

    // Stage 3: form the commands; half the knee shift goes to the knee
    always_comb begin
        h      = r_mid.st.knee_shift[StW-1:1];
        sum_ar = r_mid.ankle_roll_ref + r_mid.st.roll_flatten + r_mid.st.roll_resist;
        sum_ap = r_mid.ankle_pitch_ref + r_mid.st.pitch_flatten + r_mid.st.pitch_resist - h;
        sum_kn = r_mid.knee_ref + h;
        sum_hp = r_mid.hip_pitch_ref - h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            o_leg             <= r_mid.side;
            o_ankle_roll_cmd  <= lbc_pkg::sat_ang(sum_ar);
            o_ankle_pitch_cmd <= lbc_pkg::sat_ang(sum_ap);
            o_knee_cmd        <= lbc_pkg::sat_ang(sum_kn);
            o_hip_pitch_cmd   <= lbc_pkg::sat_ang(sum_hp);
        end
    end

    assign o_valid = r_v3;

endmodule

@@ hw/rtl/lbc_leg_state.sv @@
module lbc_leg_state (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_upd,
    input  lbc_pkg::t_item      i_item,
    input  lbc_pkg::t_cfg       i_cfg,
    output lbc_pkg::t_leg_state o_state
);

    localparam int unsigned StW   = lbc_pkg::StW;
    localparam int unsigned AngW  = lbc_pkg::AngW;
    localparam int unsigned WideW = lbc_pkg::WideW;

    lbc_pkg::t_leg_state r_st [2];
    lbc_pkg::t_leg_state cur;
    lbc_pkg::t_leg_state n_st;

    logic signed [AngW-1:0] fz, mx, my, tx, ty, kmeas, kref;
    logic signed [AngW-1:0] c_flat, c_pitch, c_roll, c_spring, c_damp, c_load;
    logic                   in_window;

    logic signed [2*AngW-1:0] p_mx, p_my, p_tx, p_ty, p_ld;
    logic signed [2*AngW:0]   r_mx, r_my, r_tx, r_ty;
    logic signed [AngW:0]     dk;
    logic signed [2*AngW:0]   p_sp;
    logic signed [AngW+StW-1:0] p_dm;
    logic signed [AngW+StW+1:0] v_kr;
    logic signed [StW:0]      s_rf, s_pf, s_rr, s_pr, s_ks;
    logic signed [StW-1:0]    kr_new;

    always_comb begin
        fz       = i_item.foot_fz;
        mx       = i_item.foot_mx;
        my       = i_item.foot_my;
        tx       = i_item.tilt_x;
        ty       = i_item.tilt_y;
        kmeas    = i_item.knee_measured;
        kref     = i_item.knee_ref;
        c_flat   = i_cfg.flatten_rate;
        c_pitch  = i_cfg.pitch_rate;
        c_roll   = i_cfg.roll_rate;
        c_spring = i_cfg.spring_rate;
        c_damp   = i_cfg.damp_rate;
        c_load   = i_cfg.load_rate;
        cur      = r_st[i_item.side];
    end

    // Gain products, rounded half up by adding half an LSB before the floor shift
    always_comb begin
        in_window = (fz > i_cfg.force_low) && (fz < i_cfg.force_high);
        p_mx = c_flat * mx;
        p_my = c_flat * my;
        p_tx = c_roll * tx;
        p_ty = c_pitch * ty;
        r_mx = p_mx + (2*AngW+1)'(signed'(17'sd16384));
        r_my = p_my + (2*AngW+1)'(signed'(17'sd16384));
        r_tx = p_tx + (2*AngW+1)'(signed'(17'sd16384));
        r_ty = p_ty + (2*AngW+1)'(signed'(17'sd16384));
    end

    // Integrators for flattening and tilt straightening
    always_comb begin
        s_rf = cur.roll_flatten  + signed'(r_mx[2*AngW:15]);
        s_pf = cur.pitch_flatten + signed'(r_my[2*AngW:15]);
        s_rr = cur.roll_resist   + signed'(r_tx[2*AngW:15]);
        s_pr = cur.pitch_resist  + signed'(r_ty[2*AngW:15]);
    end

    // Damped knee spring, then the knee shift integrator
    always_comb begin
        dk     = kref - kmeas;
        p_sp   = c_spring * dk;
        p_dm   = c_damp * cur.knee_rate;
        p_ld   = c_load * fz;
        v_kr   = p_sp - p_dm + p_ld + (AngW+StW+2)'(signed'(17'sd16384));
        kr_new = lbc_pkg::sat_st(signed'(v_kr[AngW+StW+1:15]));
        s_ks   = cur.knee_shift + kr_new;
    end

    always_comb begin
        n_st = cur;
        if (in_window) begin
            n_st.roll_flatten  = lbc_pkg::sat_st(WideW'(s_rf));
            n_st.pitch_flatten = lbc_pkg::sat_st(WideW'(s_pf));
        end
        if (i_item.single_support) begin
            n_st.roll_resist  = lbc_pkg::sat_st(WideW'(s_rr));
            n_st.pitch_resist = lbc_pkg::sat_st(WideW'(s_pr));
        end
        n_st.knee_rate  = kr_new;
        n_st.knee_shift = lbc_pkg::sat_st(WideW'(s_ks));
    end

    assign o_state = n_st;

    // Write back the selected leg when the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0] <= '0;
            r_st[1] <= '0;
        end else if (i_upd) begin
            r_st[i_item.side] <= n_st;
        end
    end

endmodule

@@ hw/rtl/lbc_checker.sv @@
`include "leg_balance_compensator_top_defines.svh"

module lbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_leg,
    input logic signed [15:0] o_knee_cmd,
    input logic signed [15:0] o_ankle_pitch_cmd
);

    // Reset empties the output stage
    `LBC_ASSERT_NEXT_ANY(a_reset_clears, !i_rst_n, !o_valid)

    // A stalled result item stays offered
    `LBC_ASSERT_NEXT(a_valid_holds, o_valid && i_stall, o_valid)

    // A stalled result item keeps its payload
    `LBC_ASSERT_NEXT(a_payload_holds, o_valid && i_stall, $stable(o_knee_cmd) && $stable(o_ankle_pitch_cmd) && $stable(o_leg))

    // With no stall downstream, an accepted item shows up on o_valid.
    `LBC_ASSERT_NEXT(a_latency, (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall, o_valid)

endmodule

bind leg_balance_compensator_top lbc_checker u_lbc_checker (.*);
